[rtl/rtt_est_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_est_pkg
// Shared types, register indexes, op codes and helper functions of the
// round-trip-time estimator.
// ----------------------------------------------------------------------------
package rtt_est_pkg;

    // Internal time width, microseconds (16 to 64)
    localparam int TIME_W  = 32;
    localparam int FIELD_W = 32;
    localparam int SHIFT_W = 4;
    localparam int CIDX_W  = 2;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [SHIFT_W-1:0] t_shift;

    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_MIGRATE = 2'd1;
    localparam logic [1:0] OP_EXPIRE  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_ALPHA_SHIFT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BETA_SHIFT  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_INITIAL_RTT = 2'd2;

    localparam t_shift ALPHA_RESET   = 4'd3;
    localparam t_shift BETA_RESET    = 4'd2;
    localparam t_field INITIAL_RESET = 32'd100000;

    typedef struct packed {
        logic [1:0] op;
        t_field     flight_time;
        t_field     peer_delay;
    } t_in_word;

    typedef struct packed {
        logic   sample_taken;
        t_field minimum_rtt;
        t_field last_rtt;
        t_field smooth_rtt;
        t_field rtt_deviation;
        t_field rtt_or_initial;
    } t_out_word;

    typedef struct packed {
        t_shift alpha_shift;
        t_shift beta_shift;
        t_field initial_rtt;
    } t_cfg;

    function automatic t_time abs_diff(input t_time a, input t_time b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Move o toward x by 1/2^k, rounding the result down to the floor of the exact value
    function automatic t_time blend(input t_time o, input t_time x, input t_shift k);
        t_time d;
        t_time mask;
        t_time step;
        mask = ~({TIME_W{1'b1}} << k);
        if (x >= o) begin
            d = x - o;
            blend = o + (d >> k);
        end else begin
            d    = o - x;
            step = (d >> k) + t_time'(|(d & mask));
            blend = o - step;
        end
    endfunction

endpackage

[rtl/rtt_estimator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_estimator_core
// Round-trip-time estimator: minimum, latest, smoothed rtt and deviation.
// ----------------------------------------------------------------------------
// Takes one word per clock unless the output stalls, and returns one result
// word per input word: the word is captured in an input register, then the
// estimator state and the result register are updated together once the
// result register is free, so a following word sees the updated state with
// no bubble. The state update loop sets the clock limit. Configuration writes
// are always accepted and should be issued only while no word is in flight.
module rtt_estimator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rtt_est_pkg::t_in_word         i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rtt_est_pkg::t_out_word        o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rtt_est_pkg::CIDX_W-1:0] i_cfg_index,
    input  rtt_est_pkg::t_field           i_cfg_data
);

    rtt_est_pkg::t_cfg      cfg;
    rtt_est_pkg::t_out_word res;
    rtt_est_pkg::t_in_word  r_in;
    rtt_est_pkg::t_out_word r_out;
    logic                   r_in_vld;
    logic                   r_out_vld;
    logic                   advance;
    logic                   fire;

    assign o_cfg_ready = 1'b1;

    rtt_est_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // result register is free when empty or being drained this cycle
    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;

    rtt_est_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

[rtl/rtt_est_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_est_cfg_regs
// Configuration registers: weight shifts and the initial rtt value.
// ----------------------------------------------------------------------------
module rtt_est_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [rtt_est_pkg::CIDX_W-1:0] i_index,
    input  rtt_est_pkg::t_field           i_data,
    output rtt_est_pkg::t_cfg             o_cfg
);

    rtt_est_pkg::t_shift r_alpha;
    rtt_est_pkg::t_shift r_beta;
    rtt_est_pkg::t_field r_initial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= rtt_est_pkg::ALPHA_RESET;
            r_beta    <= rtt_est_pkg::BETA_RESET;
            r_initial <= rtt_est_pkg::INITIAL_RESET;
        end else if (i_wr) begin
            case (i_index)
                rtt_est_pkg::CFG_ALPHA_SHIFT: r_alpha   <= i_data[rtt_est_pkg::SHIFT_W-1:0];
                rtt_est_pkg::CFG_BETA_SHIFT:  r_beta    <= i_data[rtt_est_pkg::SHIFT_W-1:0];
                rtt_est_pkg::CFG_INITIAL_RTT: r_initial <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.alpha_shift = r_alpha;
    assign o_cfg.beta_shift  = r_beta;
    assign o_cfg.initial_rtt = r_initial;

endmodule

[rtl/rtt_est_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_est_datapath
// Estimator state and its combinational next-state logic; gives the result
// word for the item held in the input register.
// ----------------------------------------------------------------------------
module rtt_est_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  rtt_est_pkg::t_in_word  i_item,
    input  rtt_est_pkg::t_cfg      i_cfg,
    output rtt_est_pkg::t_out_word o_res
);

    rtt_est_pkg::t_time r_min;
    rtt_est_pkg::t_time r_latest;
    rtt_est_pkg::t_time r_smoothed;
    rtt_est_pkg::t_time r_deviation;
    rtt_est_pkg::t_time n_min;
    rtt_est_pkg::t_time n_latest;
    rtt_est_pkg::t_time n_smoothed;
    rtt_est_pkg::t_time n_deviation;

    rtt_est_pkg::t_time delta;
    rtt_est_pkg::t_time ackd;
    rtt_est_pkg::t_time min_new;
    rtt_est_pkg::t_time sample;
    rtt_est_pkg::t_time exp_diff;
    logic               delta_ok;
    logic               taken;

    always_comb begin
        delta    = rtt_est_pkg::t_time'(i_item.flight_time);
        ackd     = rtt_est_pkg::t_time'(i_item.peer_delay);
        delta_ok = (delta != '0) && (delta != '1);
        min_new  = ((r_min == '0) || (r_min > delta)) ? delta : r_min;
        // drop the ack delay only when the sample clears the minimum by it
        sample   = ((delta - min_new) >= ackd) ? (delta - ackd) : delta;
        exp_diff = rtt_est_pkg::abs_diff(r_smoothed, r_latest);

        n_min       = r_min;
        n_latest    = r_latest;
        n_smoothed  = r_smoothed;
        n_deviation = r_deviation;
        taken       = 1'b0;

        case (i_item.op)
            rtt_est_pkg::OP_UPDATE: begin
                if (delta_ok) begin
                    taken    = 1'b1;
                    n_min    = min_new;
                    n_latest = sample;
                    if (r_smoothed == '0) begin
                        n_smoothed  = sample;
                        n_deviation = sample >> 1;
                    end else begin
                        n_deviation = rtt_est_pkg::blend(r_deviation,
                            rtt_est_pkg::abs_diff(r_smoothed, sample), i_cfg.beta_shift);
                        n_smoothed  = rtt_est_pkg::blend(r_smoothed, sample,
                            i_cfg.alpha_shift);
                    end
                end
            end
            rtt_est_pkg::OP_MIGRATE: begin
                n_min       = '0;
                n_latest    = '0;
                n_smoothed  = '0;
                n_deviation = '0;
            end
            rtt_est_pkg::OP_EXPIRE: begin
                if (exp_diff > r_deviation) begin
                    n_deviation = exp_diff;
                end
                if (r_latest > r_smoothed) begin
                    n_smoothed = r_latest;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '0;
            r_latest    <= '0;
            r_smoothed  <= '0;
            r_deviation <= '0;
        end else if (i_fire) begin
            r_min       <= n_min;
            r_latest    <= n_latest;
            r_smoothed  <= n_smoothed;
            r_deviation <= n_deviation;
        end
    end

    assign o_res.sample_taken   = taken;
    assign o_res.minimum_rtt    = rtt_est_pkg::FIELD_W'(n_min);
    assign o_res.last_rtt       = rtt_est_pkg::FIELD_W'(n_latest);
    assign o_res.smooth_rtt     = rtt_est_pkg::FIELD_W'(n_smoothed);
    assign o_res.rtt_deviation  = rtt_est_pkg::FIELD_W'(n_deviation);
    assign o_res.rtt_or_initial = (n_smoothed != '0) ?
                                  rtt_est_pkg::FIELD_W'(n_smoothed) : i_cfg.initial_rtt;

    a_taken_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && taken) |=> (r_smoothed != '0 && r_min != '0 && r_latest >= r_min))
        else $error("taken update left inconsistent state");

    a_migrate_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == rtt_est_pkg::OP_MIGRATE) |=>
        (r_min == '0 && r_latest == '0 && r_smoothed == '0 && r_deviation == '0))
        else $error("migrate did not clear state");

    a_empty_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_smoothed == '0) |-> (r_deviation == '0 && r_latest == '0))
        else $error("deviation or latest sample without smoothed rtt");

    a_expire_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == rtt_est_pkg::OP_EXPIRE) |=>
        (r_smoothed >= $past(r_smoothed) && r_deviation >= $past(r_deviation)))
        else $error("expire lowered a metric");

endmodule

[tb/rtt_est_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_est_checker
// Watches the input, result and register channels of the rtt estimator.
// Each accepted input word runs through a local copy of the estimator state.
// The predicted metrics are queued, and each result word is compared with
// the oldest one, field by field.
// ----------------------------------------------------------------------------
module rtt_est_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  rtt_est_pkg::t_in_word          i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  rtt_est_pkg::t_out_word         i_out,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rtt_est_pkg::CIDX_W-1:0] i_cfg_index,
    input  rtt_est_pkg::t_field            i_cfg_data,
    output int                             o_errors,
    output int                             o_waiting,
    output int                             o_checked,
    output int                             o_taken
);

    // Local estimator state and register copies
    rtt_est_pkg::t_time  est_min;
    rtt_est_pkg::t_time  est_last;
    rtt_est_pkg::t_time  est_smooth;
    rtt_est_pkg::t_time  est_dev;
    rtt_est_pkg::t_shift alpha_k;
    rtt_est_pkg::t_shift beta_k;
    rtt_est_pkg::t_field init_rtt;

    rtt_est_pkg::t_out_word predicted_metrics[$];

    function automatic rtt_est_pkg::t_time spread(input rtt_est_pkg::t_time a,
                                                  input rtt_est_pkg::t_time b);
        if (a > b)
            return a - b;
        return b - a;
    endfunction

    // Step from o toward x by 1/2^k; a downward step rounds up so the result
    // never drops below the floor of the exact average
    function automatic rtt_est_pkg::t_time ewma_toward(input rtt_est_pkg::t_time o,
                                                       input rtt_est_pkg::t_time x,
                                                       input rtt_est_pkg::t_shift k);
        rtt_est_pkg::t_time d;
        rtt_est_pkg::t_time lost;
        if (x >= o)
            return o + ((x - o) >> k);
        d    = o - x;
        lost = d & ((rtt_est_pkg::t_time'(1) << k) - rtt_est_pkg::t_time'(1));
        return o - (d >> k) -
               ((lost != '0) ? rtt_est_pkg::t_time'(1) : rtt_est_pkg::t_time'(0));
    endfunction

    function automatic rtt_est_pkg::t_out_word advance_estimator(
        input rtt_est_pkg::t_in_word w);
        rtt_est_pkg::t_time     s;
        rtt_est_pkg::t_time     gap;
        rtt_est_pkg::t_out_word r;
        r = '0;
        case (w.op)
            rtt_est_pkg::OP_UPDATE: begin
                if (w.flight_time != '0 && w.flight_time != '1) begin
                    r.sample_taken = 1'b1;
                    if (est_min == '0 || est_min > w.flight_time)
                        est_min = w.flight_time;
                    s = w.flight_time;
                    // strip the ack delay only when the sample stays at or above the minimum
                    if (s - est_min >= w.peer_delay)
                        s = s - w.peer_delay;
                    est_last = s;
                    if (est_smooth == '0) begin
                        est_smooth = s;
                        est_dev    = s >> 1;
                    end else begin
                        est_dev    = ewma_toward(est_dev, spread(est_smooth, s), beta_k);
                        est_smooth = ewma_toward(est_smooth, s, alpha_k);
                    end
                end
            end
            rtt_est_pkg::OP_MIGRATE: begin
                est_min    = '0;
                est_last   = '0;
                est_smooth = '0;
                est_dev    = '0;
            end
            rtt_est_pkg::OP_EXPIRE: begin
                gap = spread(est_smooth, est_last);
                if (gap > est_dev)
                    est_dev = gap;
                if (est_last > est_smooth)
                    est_smooth = est_last;
            end
            default: begin
            end
        endcase
        r.minimum_rtt    = est_min;
        r.last_rtt       = est_last;
        r.smooth_rtt     = est_smooth;
        r.rtt_deviation  = est_dev;
        r.rtt_or_initial = (est_smooth != '0) ? est_smooth : init_rtt;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input rtt_est_pkg::t_field got,
                                 input rtt_est_pkg::t_field want);
        o_errors++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    always @(posedge i_clk) begin
        rtt_est_pkg::t_out_word want;
        if (!i_rst_n) begin
            est_min    = '0;
            est_last   = '0;
            est_smooth = '0;
            est_dev    = '0;
            alpha_k    = rtt_est_pkg::ALPHA_RESET;
            beta_k     = rtt_est_pkg::BETA_RESET;
            init_rtt   = rtt_est_pkg::INITIAL_RESET;
            predicted_metrics.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rtt_est_pkg::CFG_ALPHA_SHIFT:
                        alpha_k  = i_cfg_data[rtt_est_pkg::SHIFT_W-1:0];
                    rtt_est_pkg::CFG_BETA_SHIFT:
                        beta_k   = i_cfg_data[rtt_est_pkg::SHIFT_W-1:0];
                    rtt_est_pkg::CFG_INITIAL_RTT:
                        init_rtt = i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (predicted_metrics.size() == 0) begin
                    note_mismatch("result word with nothing pending", i_out.smooth_rtt, '0);
                end else begin
                    want = predicted_metrics.pop_front();
                    o_checked++;
                    if (i_out.sample_taken !== want.sample_taken)
                        note_mismatch("sample_taken",
                                      rtt_est_pkg::t_field'(i_out.sample_taken),
                                      rtt_est_pkg::t_field'(want.sample_taken));
                    if (i_out.minimum_rtt !== want.minimum_rtt)
                        note_mismatch("minimum_rtt", i_out.minimum_rtt, want.minimum_rtt);
                    if (i_out.last_rtt !== want.last_rtt)
                        note_mismatch("last_rtt", i_out.last_rtt, want.last_rtt);
                    if (i_out.smooth_rtt !== want.smooth_rtt)
                        note_mismatch("smooth_rtt", i_out.smooth_rtt, want.smooth_rtt);
                    if (i_out.rtt_deviation !== want.rtt_deviation)
                        note_mismatch("rtt_deviation", i_out.rtt_deviation, want.rtt_deviation);
                    if (i_out.rtt_or_initial !== want.rtt_or_initial)
                        note_mismatch("rtt_or_initial", i_out.rtt_or_initial,
                                      want.rtt_or_initial);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                want = advance_estimator(i_in);
                if (want.sample_taken)
                    o_taken++;
                predicted_metrics.push_back(want);
            end
        end
        o_waiting = predicted_metrics.size();
    end

endmodule

[tb/tb_rtt_estimator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtt_estimator_core
// Drives the rtt estimator through a directed set of samples, migrations and
// expiries, then through random traffic under several register settings.
// Both channels idle and stall at random, and one long receiver hold-off
// backs the block up. The result checking lives in rtt_est_checker.
// ----------------------------------------------------------------------------
module tb_rtt_estimator_core;

    localparam logic [1:0]                     OP_UNUSED        = 2'd3;
    localparam logic [rtt_est_pkg::CIDX_W-1:0] CFG_UNUSED       = 2'd3;
    localparam int                             N_SETTINGS       = 7;
    localparam int                             RAND_PER_SETTING = 185;
    localparam int                             HOLD_CYCLES      = 300;
    localparam int                             DRAIN_CYCLES     = 8;
    localparam int unsigned                    CYCLE_LIMIT      = 400000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    rtt_est_pkg::t_in_word          in_word;
    logic                           out_valid;
    logic                           out_stall;
    rtt_est_pkg::t_out_word         out_word;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rtt_est_pkg::CIDX_W-1:0] cfg_index;
    rtt_est_pkg::t_field            cfg_data;

    int          errors;
    int          waiting;
    int          checked;
    int          taken;
    int          words_sent   = 0;
    int          input_blocked = 0;
    int unsigned cycle_count  = 0;
    bit          quiet_in     = 1'b0;
    bit          quiet_out    = 1'b0;
    bit          hold_off_req = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    rtt_estimator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rtt_est_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_checked   (checked),
        .o_taken     (taken)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (in_valid && in_stall)
            input_blocked <= input_blocked + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending", cycle_count, waiting);
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stall bursts, quiet stretches, and one long hold-off
    initial begin
        int unsigned n;
        out_stall = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end else if (quiet_out) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                n = idle_len();
                if (n != 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Leave valid high on return; the next call or the caller lowers it
    task automatic push_word(input logic [1:0] op, input rtt_est_pkg::t_field delta,
                             input rtt_est_pkg::t_field ack);
        int unsigned           gap;
        rtt_est_pkg::t_in_word w;
        gap           = quiet_in ? 0 : idle_len();
        w.op          = op;
        w.flight_time = delta;
        w.peer_delay  = ack;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic write_reg(input logic [rtt_est_pkg::CIDX_W-1:0] idx,
                             input rtt_est_pkg::t_field data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Sample the pending count away from the rising edge
    task automatic wait_drained();
        do @(negedge clk); while (waiting != 0);
        @(posedge clk);
    endtask

    function automatic rtt_est_pkg::t_in_word random_word();
        rtt_est_pkg::t_in_word w;
        int unsigned           r;
        r = $urandom_range(0, 9);
        if (r < 6)
            w.flight_time = $urandom_range(2000, 300000);
        else if (r == 6)
            w.flight_time = $urandom_range(1, 64);
        else if (r == 7)
            w.flight_time = $urandom;
        else if (r == 8)
            w.flight_time = 32'hFFFF_FFFE - $urandom_range(0, 100);
        else
            w.flight_time = $urandom_range(1, 2000000);
        r = $urandom_range(0, 9);
        if (r < 3)
            w.peer_delay = '0;
        else if (r < 8)
            w.peer_delay = $urandom_range(0, 25000);
        else if (r == 8)
            w.peer_delay = $urandom;
        else
            w.peer_delay = $urandom_range(0, 300000);
        w.op = rtt_est_pkg::OP_UPDATE;
        r = $urandom_range(0, 99);
        if (r < 4)
            w.op = rtt_est_pkg::OP_MIGRATE;
        else if (r < 14)
            w.op = rtt_est_pkg::OP_EXPIRE;
        else if (r < 17)
            w.op = OP_UNUSED;
        else if (r < 19)
            w.flight_time = '0;
        else if (r < 21)
            w.flight_time = '1;
        return w;
    endfunction

    initial begin
        rtt_est_pkg::t_in_word w;
        rtt_est_pkg::t_shift   a;
        rtt_est_pkg::t_shift   b;
        rtt_est_pkg::t_field   init_val;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    a        = rtt_est_pkg::ALPHA_RESET;
                    b        = rtt_est_pkg::BETA_RESET;
                    init_val = rtt_est_pkg::INITIAL_RESET;
                end
                1: begin
                    a        = '0;
                    b        = '0;
                    init_val = '0;
                end
                2: begin
                    a        = '1;
                    b        = '1;
                    init_val = '1;
                end
                3: begin
                    a        = 4'd1;
                    b        = 4'd8;
                    init_val = $urandom;
                end
                4: begin
                    a        = 4'd8;
                    b        = 4'd1;
                    init_val = $urandom_range(1, 1000);
                end
                default: begin
                    a        = $urandom_range(1, 8);
                    b        = $urandom_range(1, 8);
                    init_val = $urandom;
                end
            endcase
            // unused register index must leave every setting alone
            if (ph == 1)
                write_reg(CFG_UNUSED, $urandom);
            write_reg(rtt_est_pkg::CFG_ALPHA_SHIFT,
                      {(ph % 2 != 0) ? 28'($urandom) : 28'd0, a});
            write_reg(rtt_est_pkg::CFG_BETA_SHIFT,
                      {(ph % 2 != 0) ? 28'($urandom) : 28'd0, b});
            write_reg(rtt_est_pkg::CFG_INITIAL_RTT, init_val);
            cfg_valid <= 1'b0;

            quiet_in  = (ph % 3 == 1);
            quiet_out = (ph % 4 == 3);
            if (ph == 2)
                hold_off_req = 1'b1;

            if (ph == 0) begin
                push_word(rtt_est_pkg::OP_EXPIRE, '0, '0);
                push_word(OP_UNUSED, '1, '1);
                push_word(rtt_est_pkg::OP_UPDATE, '0, 32'd500);
                push_word(rtt_est_pkg::OP_UPDATE, '1, '0);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd1, '0);
                push_word(rtt_est_pkg::OP_UPDATE, 32'hFFFF_FFFE, '1);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd5000, 32'd1000);
                push_word(rtt_est_pkg::OP_EXPIRE, '1, '1);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd3000, 32'd2999);
                push_word(rtt_est_pkg::OP_EXPIRE, '0, '0);
                push_word(rtt_est_pkg::OP_MIGRATE, '1, '1);
                push_word(rtt_est_pkg::OP_EXPIRE, '0, '0);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd40000, 32'd40000);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd20000, '0);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd80000, 32'd60000);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd2, 32'd1);
                push_word(rtt_est_pkg::OP_UPDATE, 32'hFFFF_FFFE, '0);
                push_word(rtt_est_pkg::OP_EXPIRE, '0, '0);
                push_word(OP_UNUSED, '0, '0);
                push_word(rtt_est_pkg::OP_UPDATE, 32'd1, '1);
                push_word(rtt_est_pkg::OP_MIGRATE, '0, '0);
            end

            for (int i = 0; i < RAND_PER_SETTING; i++) begin
                w = random_word();
                push_word(w.op, w.flight_time, w.peer_delay);
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d register settings with %0d input words, %0d samples applied",
                 N_SETTINGS, words_sent, taken);
        $display("compared %0d result words; input held back for %0d cycles",
                 checked, input_blocked);
        if (errors == 0 && waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/rtt_est_pkg.sv
rtl/rtt_est_cfg_regs.sv
rtl/rtt_est_datapath.sv
rtl/rtt_estimator_core.sv
tb/rtt_est_checker.sv
tb/tb_rtt_estimator_core.sv
